[sv/rph_pkg.sv]
// Package for the RADIUS password hiding unit: MD5 constants, types, helpers.
// No dependencies.
`timescale 1ns / 1ps
package rph_pkg;

	localparam int MaxSecretBytes = 32;
	localparam int BlockBytes     = 16;
	localparam int CfgIdxW        = 3;
	localparam int CfgDataW       = 64;
	localparam int SecLenW        = 6;

	localparam logic [CfgIdxW-1:0] REG_SECRET_LEN = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SECRET_W0  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SECRET_W1  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SECRET_W2  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SECRET_W3  = 3'd4;

	localparam logic FUNC_HIDE   = 1'b0;
	localparam logic FUNC_REVEAL = 1'b1;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	typedef struct packed {
		logic        func;
		logic        last;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic        use_chain;
		logic [63:0] data_hi;
		logic [63:0] data_lo;
	} job_t;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        last;
	} res_t;

	typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_DONE} eng_state_t;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s;
		unique case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] bswap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

[sv/rph_if.sv]
// Valid/ready channel interfaces for the password hiding unit.
// Depends on nothing.
`timescale 1ns / 1ps
interface rph_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic        first_block;
	logic [63:0] nonce_hi;
	logic [63:0] nonce_lo;
	logic [63:0] data_hi;
	logic [63:0] data_lo;
	logic        last_block;
	modport source (output valid, func, first_block, nonce_hi, nonce_lo, data_hi,
		data_lo, last_block, input ready);
	modport sink (input valid, func, first_block, nonce_hi, nonce_lo, data_hi,
		data_lo, last_block, output ready);
endinterface

interface rph_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_hi;
	logic [63:0] out_lo;
	logic        out_last;
	modport source (output valid, out_hi, out_lo, out_last, input ready);
	modport sink (input valid, out_hi, out_lo, out_last, output ready);
endinterface

[sv/rph_front.sv]
// Front end: accepts requests and queues them as jobs (two-entry queue).
// Depends on rph_pkg, rph_if.
`timescale 1ns / 1ps
module rph_front
	import rph_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	rph_in_if.sink in_ch,
	output job_t   job,
	output logic   job_valid,
	input  logic   job_take
);
	job_t       q_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;
	job_t       nj;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign job_valid   = (cnt_q != 2'd0);
	assign job         = q_q[rd_q];

	always_comb begin
		nj.func      = in_ch.func;
		nj.last      = in_ch.last_block;
		nj.key_hi    = in_ch.nonce_hi;
		nj.key_lo    = in_ch.nonce_lo;
		nj.use_chain = !in_ch.first_block;
		nj.data_hi   = in_ch.data_hi;
		nj.data_lo   = in_ch.data_lo;
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (job_take && job_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(job_take && job_valid);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) job_take |-> job_valid)
		else $error("take from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !job_take) |=> cnt_q == 2'd2)
		else $error("full queue lost entry");
endmodule

[sv/rph_back.sv]
// Back end: MD5 over secret||key, one round per cycle, XOR and chain update.
// Depends on rph_pkg.
`timescale 1ns / 1ps
module rph_back
	import rph_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SecLenW-1:0]  secret_len,
	input  logic [255:0]        secret,
	input  job_t                job,
	input  logic                job_valid,
	output logic                job_take,
	output res_t                res,
	output logic                res_valid,
	input  logic                res_ready
);
	eng_state_t  st_q, st_d;
	logic [5:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [511:0] m_q;
	logic [63:0] chain_hi_q, chain_lo_q;
	logic [63:0] dh_q, dl_q;
	logic        func_q, last_q;
	logic        res_valid_q;
	res_t        res_q;

	logic [511:0] msg;
	logic [5:0]   slen;
	logic [63:0]  khi, klo;
	logic [127:0] key;
	logic [8:0]   bits;
	logic [3:0]   g;
	logic [31:0]  f, w, sum, rot, nb;
	logic [127:0] dig;
	logic         start, finish;

	assign slen = (secret_len > 6'(MaxSecretBytes)) ? 6'(MaxSecretBytes) : secret_len;
	assign khi  = job.use_chain ? chain_hi_q : job.key_hi;
	assign klo  = job.use_chain ? chain_lo_q : job.key_lo;
	assign key  = {khi, klo};
	assign bits = 9'(({3'd0, slen} + 9'(BlockBytes)) << 3);

	always_comb begin
		msg = '0;
		for (int i = 0; i < 56; i++) begin
			if (i < int'(slen)) msg[511-8*i -: 8] = secret[255-8*i -: 8];
			else if (i < int'(slen) + BlockBytes)
				msg[511-8*i -: 8] = key[127-8*(i-int'(slen)) -: 8];
			else if (i == int'(slen) + BlockBytes) msg[511-8*i -: 8] = 8'h80;
		end
		msg[63:56] = bits[7:0];
		msg[55:48] = {7'd0, bits[8]};
	end

	always_comb begin
		unique case (rnd_q[5:4])
			2'd0: begin f = (b_q & c_q) | (~b_q & d_q); g = rnd_q[3:0]; end
			2'd1: begin f = (b_q & d_q) | (c_q & ~d_q); g = 4'(5*rnd_q + 1); end
			2'd2: begin f = b_q ^ c_q ^ d_q; g = 4'(3*rnd_q + 5); end
			default: begin f = c_q ^ (b_q | ~d_q); g = 4'(7*rnd_q); end
		endcase
		w   = bswap32(m_q[511-32*g -: 32]);
		sum = f + a_q + md5_k(rnd_q) + w;
		rot = (sum << md5_s(rnd_q)) | (sum >> (6'd32 - {1'b0, md5_s(rnd_q)}));
		nb  = b_q + rot;
	end

	assign dig = {bswap32(IV_A + a_q), bswap32(IV_B + b_q),
		bswap32(IV_C + c_q), bswap32(IV_D + d_q)};

	assign start    = (st_q == ST_IDLE) && job_valid;
	assign finish   = (st_q == ST_DONE) && (!res_valid_q || res_ready);
	assign job_take = start;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (job_valid) st_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 6'd63) st_d = ST_DONE;
			ST_DONE:  if (finish) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			rnd_q       <= 6'd0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (start) rnd_q <= 6'd0;
			else if (st_q == ST_ROUND) rnd_q <= rnd_q + 6'd1;
			if (finish) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q    <= msg;
			a_q    <= IV_A; b_q <= IV_B; c_q <= IV_C; d_q <= IV_D;
			dh_q   <= job.data_hi;
			dl_q   <= job.data_lo;
			func_q <= job.func;
			last_q <= job.last;
		end else if (st_q == ST_ROUND) begin
			a_q <= d_q; b_q <= nb; c_q <= b_q; d_q <= c_q;
		end
		if (finish) begin
			res_q.hi   <= dh_q ^ dig[127:64];
			res_q.lo   <= dl_q ^ dig[63:0];
			res_q.last <= last_q;
			chain_hi_q <= (func_q == FUNC_REVEAL) ? dh_q : dh_q ^ dig[127:64];
			chain_lo_q <= (func_q == FUNC_REVEAL) ? dl_q : dl_q ^ dig[63:0];
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |=> st_q == ST_ROUND)
		else $error("start did not enter rounds");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND && rnd_q == 6'd63) |=> st_q == ST_DONE)
		else $error("round count mismatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |=> res_valid_q)
		else $error("result dropped");
endmodule

[sv/radius_password_hiding_unit.sv]
// Top level of the RADIUS password hiding unit: config registers, front, back.
// Depends on rph_pkg, rph_if, rph_front, rph_back.
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | func first_block nonce_hi/lo data_hi/lo last_block
//  out_ch   | out | valid/ready   | out_hi out_lo out_last
//  cfg      | in  | cfg_we        | cfg_idx cfg_data
//
// In the back end a block goes through load, 64 MD5 rounds and finish.
// The MD5 datapath computes a single round at a time; a two-entry queue feeds it.
// Reset clears control state and the config registers; chain key is unset.
// A held result stalls only the finish step; the queue keeps taking requests until its two entries are full.
`timescale 1ns / 1ps
module radius_password_hiding_unit
	import rph_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	rph_in_if.sink              in_ch,
	rph_out_if.source           out_ch
);
	logic [SecLenW-1:0] secret_len_q;
	logic [255:0]       secret_q;
	job_t               job;
	logic               job_valid, job_take;
	res_t               res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_len_q <= '0;
			secret_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SECRET_LEN: secret_len_q <= cfg_data[SecLenW-1:0];
				REG_SECRET_W0:  secret_q[255:192] <= cfg_data;
				REG_SECRET_W1:  secret_q[191:128] <= cfg_data;
				REG_SECRET_W2:  secret_q[127:64]  <= cfg_data;
				REG_SECRET_W3:  secret_q[63:0]    <= cfg_data;
				default: ;
			endcase
		end
	end

	rph_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.job(job), .job_valid(job_valid), .job_take(job_take)
	);

	rph_back u_back (
		.clk(clk), .arst_n(arst_n), .secret_len(secret_len_q), .secret(secret_q),
		.job(job), .job_valid(job_valid), .job_take(job_take),
		.res(res), .res_valid(out_ch.valid), .res_ready(out_ch.ready)
	);

	assign out_ch.out_hi   = res.hi;
	assign out_ch.out_lo   = res.lo;
	assign out_ch.out_last = res.last;
endmodule
